// ----- src/gdr_pkg.sv -----
// gdr_pkg: shared types and constants of the grid dda raycaster
// states of the cast sequencer, register indexes, command codes
// no dependencies
`timescale 1ns / 1ps

package gdr_pkg;

    localparam int MAP_WIDTH_DEF  = 64;
    localparam int MAP_HEIGHT_DEF = 64;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [15:0] POS_X_RST         = 16'd2048;
    localparam logic [15:0] POS_Y_RST         = 16'd2048;
    localparam logic [15:0] DIR_X_RST         = 16'hC000;
    localparam logic [15:0] DIR_Y_RST         = 16'h0000;
    localparam logic [15:0] PLANE_X_RST       = 16'h0000;
    localparam logic [15:0] PLANE_Y_RST       = 16'd10813;

    localparam logic [41:0] TENTH_Q16 = 42'd6554;

    typedef enum logic {
        CMD_WRITE_CELL = 1'b0,
        CMD_CAST       = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_POS_X         = 3'd2,
        REG_POS_Y         = 3'd3,
        REG_DIR_X         = 3'd4,
        REG_DIR_Y         = 3'd5,
        REG_PLANE_X       = 3'd6,
        REG_PLANE_Y       = 3'd7
    } t_reg;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CAM_LD,
        S_DIV,
        S_CAM_FIN,
        S_MUL_X,
        S_RDX,
        S_MUL_Y,
        S_RDY,
        S_DX_LD,
        S_DX_FIN,
        S_DY_LD,
        S_DY_FIN,
        S_SX_MUL,
        S_SX_FIN,
        S_SY_MUL,
        S_SY_FIN,
        S_STEP,
        S_TEST,
        S_PERP,
        S_LH_LD,
        S_LH_FIN,
        S_DONE
    } t_state;

endpackage

// ----- src/gdr_if.sv -----
// gdr_in_if, gdr_out_if: valid/ready channels of the raycaster
// input carries cell writes and cast requests, output carries wall columns
// no dependencies
`timescale 1ns / 1ps

interface gdr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic        cell_is_wall;
    logic [11:0] column;

    modport source (output valid, cmd, cell_col, cell_row, cell_is_wall, column,
                    input ready);
    modport sink   (input valid, cmd, cell_col, cell_row, cell_is_wall, column,
                    output ready);
endinterface

interface gdr_out_if;
    logic              valid;
    logic              ready;
    logic [11:0]       out_column;
    logic              wall_side;
    logic signed [7:0] hit_col;
    logic signed [7:0] hit_row;
    logic [15:0]       perp_distance;
    logic [15:0]       line_height;
    logic [11:0]       draw_start;
    logic [11:0]       draw_end;

    modport source (output valid, out_column, wall_side, hit_col, hit_row,
                    perp_distance, line_height, draw_start, draw_end,
                    input ready);
    modport sink   (input valid, out_column, wall_side, hit_col, hit_row,
                    perp_distance, line_height, draw_start, draw_end,
                    output ready);
endinterface

// ----- src/grid_dda_raycast_column.sv -----
// grid_dda_raycast_column: one-ray-per-column dda raycaster over a wall grid
// cell write: input stays ready; cast: result valid once the ray hits a wall or leaves, a step
// state and a map test per dda step (one shared 32-step divider used four times, one shared
// multiplier); an untaken result holds the next one in the done state
// one cast at a time; input not ready while a cast runs, result held in an
// output register; after reset a clearing pass empties all 2^(clog2(MAP_WIDTH)+
// clog2(MAP_HEIGHT)) map cells (4096 by default), configuration from gdr_pkg reset values
`timescale 1ns / 1ps

module grid_dda_raycast_column #(
    parameter int MAP_WIDTH  = gdr_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = gdr_pkg::MAP_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdr_in_if.sink      i_in,
    gdr_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(MAP_WIDTH);
    localparam int RW    = $clog2(MAP_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [9:0] MW10 = 10'(MAP_WIDTH);
    localparam logic signed [9:0] MH10 = 10'(MAP_HEIGHT);

    gdr_pkg::t_state r_state, n_state, r_ret, n_ret;

    // configuration
    logic [11:0]        r_sw, r_sh;
    logic [15:0]        r_px, r_py;
    logic signed [15:0] r_dirx, r_diry, r_plx, r_ply;

    // map memory
    logic          mem [DEPTH];
    logic          r_rd;
    logic [AW-1:0] r_clr;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic          mem_wd;

    // datapath
    logic [11:0]        r_col;
    logic               r_camneg;
    logic signed [27:0] r_cam;
    logic signed [29:0] r_rdx, r_rdy;
    logic [31:0]        r_dx, r_dy;
    logic [41:0]        r_sx, r_sy;
    logic signed [9:0]  r_mx, r_my;
    logic               r_side, r_outside;
    logic [41:0]        r_perp;
    logic [15:0]        r_lh;

    logic signed [28:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [61:0] r_prod;

    logic [31:0] r_quo;
    logic [41:0] r_rem, r_den;
    logic [4:0]  r_dcnt;
    logic        div_ld;
    logic [31:0] div_num;
    logic [41:0] div_den;
    logic [42:0] div_t;
    logic        div_ge;

    logic [11:0]        w0;
    logic signed [13:0] dcam;
    logic [13:0]        dcam_abs;
    logic [26:0]        cam_q;
    logic signed [47:0] prod_sh;
    logic [29:0]        rdx_abs, rdy_abs;
    logic [10:0]        fracx, fracy;
    logic               step_x;
    logic signed [9:0]  step_mx, step_my;
    logic               step_out;
    logic [41:0]        perp_raw;
    logic [10:0]        half;
    logic [14:0]        lh2;
    logic [15:0]        de_sum;
    logic [11:0]        ds_v, de_v;
    logic [8:0]         wcol9, wrow9;
    logic               in_acc, cfg_we, done_ld;

    // output register
    logic              r_ov;
    logic [11:0]       r_ocol;
    logic              r_oside;
    logic signed [7:0] r_ohc, r_ohr;
    logic [15:0]       r_operp, r_olh;
    logic [11:0]       r_ods, r_ode;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign i_in.ready = (r_state == gdr_pkg::S_IDLE);
    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        case (gdr_pkg::t_reg'(paddr[4:2]))
            gdr_pkg::REG_SCREEN_WIDTH:  prdata = {20'b0, r_sw};
            gdr_pkg::REG_SCREEN_HEIGHT: prdata = {20'b0, r_sh};
            gdr_pkg::REG_POS_X:         prdata = {16'b0, r_px};
            gdr_pkg::REG_POS_Y:         prdata = {16'b0, r_py};
            gdr_pkg::REG_DIR_X:         prdata = {16'b0, r_dirx};
            gdr_pkg::REG_DIR_Y:         prdata = {16'b0, r_diry};
            gdr_pkg::REG_PLANE_X:       prdata = {16'b0, r_plx};
            gdr_pkg::REG_PLANE_Y:       prdata = {16'b0, r_ply};
            default:                    prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= gdr_pkg::SCREEN_WIDTH_RST;
            r_sh   <= gdr_pkg::SCREEN_HEIGHT_RST;
            r_px   <= gdr_pkg::POS_X_RST;
            r_py   <= gdr_pkg::POS_Y_RST;
            r_dirx <= gdr_pkg::DIR_X_RST;
            r_diry <= gdr_pkg::DIR_Y_RST;
            r_plx  <= gdr_pkg::PLANE_X_RST;
            r_ply  <= gdr_pkg::PLANE_Y_RST;
        end else if (cfg_we) begin
            case (gdr_pkg::t_reg'(paddr[4:2]))
                gdr_pkg::REG_SCREEN_WIDTH:  r_sw   <= pwdata[11:0];
                gdr_pkg::REG_SCREEN_HEIGHT: r_sh   <= pwdata[11:0];
                gdr_pkg::REG_POS_X:         r_px   <= pwdata[15:0];
                gdr_pkg::REG_POS_Y:         r_py   <= pwdata[15:0];
                gdr_pkg::REG_DIR_X:         r_dirx <= pwdata[15:0];
                gdr_pkg::REG_DIR_Y:         r_diry <= pwdata[15:0];
                gdr_pkg::REG_PLANE_X:       r_plx  <= pwdata[15:0];
                gdr_pkg::REG_PLANE_Y:       r_ply  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            gdr_pkg::S_CLEAR:
                if (r_clr == AW'(DEPTH - 1)) n_state = gdr_pkg::S_IDLE;
            gdr_pkg::S_IDLE:
                if (in_acc && i_in.cmd == gdr_pkg::CMD_CAST) n_state = gdr_pkg::S_CAM_LD;
            gdr_pkg::S_CAM_LD: begin
                n_state = gdr_pkg::S_DIV;
                n_ret   = gdr_pkg::S_CAM_FIN;
            end
            gdr_pkg::S_DIV:
                if (r_dcnt == 5'd31) n_state = r_ret;
            gdr_pkg::S_CAM_FIN: n_state = gdr_pkg::S_MUL_X;
            gdr_pkg::S_MUL_X:   n_state = gdr_pkg::S_RDX;
            gdr_pkg::S_RDX:     n_state = gdr_pkg::S_MUL_Y;
            gdr_pkg::S_MUL_Y:   n_state = gdr_pkg::S_RDY;
            gdr_pkg::S_RDY:     n_state = gdr_pkg::S_DX_LD;
            gdr_pkg::S_DX_LD: begin
                n_state = gdr_pkg::S_DIV;
                n_ret   = gdr_pkg::S_DX_FIN;
            end
            gdr_pkg::S_DX_FIN:  n_state = gdr_pkg::S_DY_LD;
            gdr_pkg::S_DY_LD: begin
                n_state = gdr_pkg::S_DIV;
                n_ret   = gdr_pkg::S_DY_FIN;
            end
            gdr_pkg::S_DY_FIN:  n_state = gdr_pkg::S_SX_MUL;
            gdr_pkg::S_SX_MUL:  n_state = gdr_pkg::S_SX_FIN;
            gdr_pkg::S_SX_FIN:  n_state = gdr_pkg::S_SY_MUL;
            gdr_pkg::S_SY_MUL:  n_state = gdr_pkg::S_SY_FIN;
            gdr_pkg::S_SY_FIN:  n_state = gdr_pkg::S_STEP;
            gdr_pkg::S_STEP:    n_state = gdr_pkg::S_TEST;
            gdr_pkg::S_TEST:
                n_state = (r_outside || r_rd) ? gdr_pkg::S_PERP : gdr_pkg::S_STEP;
            gdr_pkg::S_PERP:    n_state = gdr_pkg::S_LH_LD;
            gdr_pkg::S_LH_LD: begin
                n_state = gdr_pkg::S_DIV;
                n_ret   = gdr_pkg::S_LH_FIN;
            end
            gdr_pkg::S_LH_FIN:  n_state = gdr_pkg::S_DONE;
            gdr_pkg::S_DONE:
                if (!r_ov || o_out.ready) n_state = gdr_pkg::S_IDLE;
            default:            n_state = gdr_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w0       = (r_sw == 12'd0) ? 12'd1 : r_sw;
        dcam     = $signed({1'b0, r_col, 1'b0}) - $signed({2'b0, w0});
        dcam_abs = dcam[13] ? 14'(-dcam) : 14'(dcam);
        cam_q    = r_quo[26:0];
        prod_sh  = r_prod[61] ? 48'((r_prod + 62'sd16383) >>> 14) : 48'(r_prod >>> 14);
        rdx_abs  = r_rdx[29] ? 30'(-r_rdx) : 30'(r_rdx);
        rdy_abs  = r_rdy[29] ? 30'(-r_rdy) : 30'(r_rdy);
        fracx    = r_rdx[29] ? {1'b0, r_px[9:0]} : 11'd1024 - {1'b0, r_px[9:0]};
        fracy    = r_rdy[29] ? {1'b0, r_py[9:0]} : 11'd1024 - {1'b0, r_py[9:0]};

        step_x   = r_sx < r_sy;
        step_mx  = r_mx;
        step_my  = r_my;
        if (step_x) step_mx = r_mx + (r_rdx[29] ? -10'sd1 : 10'sd1);
        else        step_my = r_my + (r_rdy[29] ? -10'sd1 : 10'sd1);
        step_out = step_mx < 0 || step_my < 0 || step_mx >= MW10 || step_my >= MH10;
        perp_raw = r_side ? r_sy - {10'b0, r_dy} : r_sx - {10'b0, r_dx};

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            gdr_pkg::S_MUL_X: begin
                mul_a = 29'(r_plx);
                mul_b = 33'(r_cam);
            end
            gdr_pkg::S_MUL_Y: begin
                mul_a = 29'(r_ply);
                mul_b = 33'(r_cam);
            end
            gdr_pkg::S_SX_MUL: begin
                mul_a = $signed({18'b0, fracx});
                mul_b = $signed({1'b0, r_dx});
            end
            gdr_pkg::S_SY_MUL: begin
                mul_a = $signed({18'b0, fracy});
                mul_b = $signed({1'b0, r_dy});
            end
            default: ;
        endcase

        div_ld  = 1'b1;
        div_num = '0;
        div_den = '0;
        case (r_state)
            gdr_pkg::S_CAM_LD: begin
                div_num = {5'b0, dcam_abs[12:0], 14'b0};
                div_den = {30'b0, w0};
            end
            gdr_pkg::S_DX_LD: begin
                div_num = 32'h4000_0000;
                div_den = {12'b0, rdx_abs};
            end
            gdr_pkg::S_DY_LD: begin
                div_num = 32'h4000_0000;
                div_den = {12'b0, rdy_abs};
            end
            gdr_pkg::S_LH_LD: begin
                div_num = {4'b0, r_sh, 16'b0};
                div_den = r_perp;
            end
            default: div_ld = 1'b0;
        endcase
        div_t  = {r_rem, r_quo[31]};
        div_ge = div_t >= {1'b0, r_den};

        half   = r_sh[11:1];
        lh2    = r_lh[15:1];
        ds_v   = ({5'b0, half} > {1'b0, lh2}) ? 12'({5'b0, half} - {1'b0, lh2}) : 12'd0;
        de_sum = {5'b0, half} + {1'b0, lh2};
        if (r_sh == 12'd0)                de_v = 12'd0;
        else if (de_sum >= {4'b0, r_sh})  de_v = r_sh - 12'd1;
        else                              de_v = de_sum[11:0];
        done_ld = (r_state == gdr_pkg::S_DONE) && (!r_ov || o_out.ready);

        wcol9  = {3'b0, i_in.cell_col};
        wrow9  = {3'b0, i_in.cell_row};
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 1'b0;
        if (r_state == gdr_pkg::S_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && i_in.cmd == gdr_pkg::CMD_WRITE_CELL
                     && wcol9 < 9'(MAP_WIDTH) && wrow9 < 9'(MAP_HEIGHT)) begin
            mem_we = 1'b1;
            mem_wa = {wrow9[RW-1:0], wcol9[CW-1:0]};
            mem_wd = i_in.cell_is_wall;
        end
        mem_ra = {step_my[RW-1:0], step_mx[CW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdr_pkg::S_CLEAR;
            r_ret   <= gdr_pkg::S_IDLE;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (r_state == gdr_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
            if (done_ld)          r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (div_ld) begin
            r_quo  <= div_num;
            r_rem  <= '0;
            r_den  <= div_den;
            r_dcnt <= '0;
        end else if (r_state == gdr_pkg::S_DIV) begin
            r_quo  <= {r_quo[30:0], div_ge};
            r_rem  <= div_ge ? 42'(div_t - {1'b0, r_den}) : div_t[41:0];
            r_dcnt <= r_dcnt + 5'd1;
        end
        case (r_state)
            gdr_pkg::S_IDLE:    r_col <= i_in.column;
            gdr_pkg::S_CAM_LD:  r_camneg <= dcam[13];
            gdr_pkg::S_CAM_FIN:
                r_cam <= r_camneg ? -$signed({1'b0, cam_q}) : $signed({1'b0, cam_q});
            gdr_pkg::S_RDX:     r_rdx <= 30'(r_dirx) + prod_sh[29:0];
            gdr_pkg::S_RDY:     r_rdy <= 30'(r_diry) + prod_sh[29:0];
            gdr_pkg::S_DX_FIN:  r_dx <= (r_rdx == 30'sd0) ? 32'hFFFF_FFFF : r_quo;
            gdr_pkg::S_DY_FIN:  r_dy <= (r_rdy == 30'sd0) ? 32'hFFFF_FFFF : r_quo;
            gdr_pkg::S_SX_FIN: begin
                r_sx <= {10'b0, r_prod[41:10]};
                r_mx <= $signed({4'b0, r_px[15:10]});
            end
            gdr_pkg::S_SY_FIN: begin
                r_sy <= {10'b0, r_prod[41:10]};
                r_my <= $signed({4'b0, r_py[15:10]});
            end
            gdr_pkg::S_STEP: begin
                if (step_x) r_sx <= r_sx + {10'b0, r_dx};
                else        r_sy <= r_sy + {10'b0, r_dy};
                r_mx      <= step_mx;
                r_my      <= step_my;
                r_side    <= !step_x;
                r_outside <= step_out;
            end
            gdr_pkg::S_PERP:    r_perp <= (perp_raw == 42'd0) ? gdr_pkg::TENTH_Q16 : perp_raw;
            gdr_pkg::S_LH_FIN:  r_lh <= (|r_quo[31:16]) ? 16'hFFFF : r_quo[15:0];
            default: ;
        endcase
        if (done_ld) begin
            r_ocol  <= r_col;
            r_oside <= r_side;
            r_ohc   <= r_mx[7:0];
            r_ohr   <= r_my[7:0];
            r_operp <= (|r_perp[41:24]) ? 16'hFFFF : r_perp[23:8];
            r_olh   <= r_lh;
            r_ods   <= ds_v;
            r_ode   <= de_v;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.out_column    = r_ocol;
    assign o_out.wall_side     = r_oside;
    assign o_out.hit_col       = r_ohc;
    assign o_out.hit_row       = r_ohr;
    assign o_out.perp_distance = r_operp;
    assign o_out.line_height   = r_olh;
    assign o_out.draw_start    = r_ods;
    assign o_out.draw_end      = r_ode;

endmodule

// ----- src/gdr_checker.sv -----
// gdr_checker: port-level assertions for grid_dda_raycast_column
// bound to the top level; sees channel handshakes and result fields only
`timescale 1ns / 1ps

module gdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_out_column,
    input logic [11:0] i_draw_start,
    input logic [11:0] i_draw_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_column))
        else $error("stalled result changed");

    // a cast keeps the input busy
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == gdr_pkg::CMD_CAST |=> !i_in_ready)
        else $error("ready during cast");

    // a cell write leaves the input ready
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == gdr_pkg::CMD_WRITE_CELL |=> i_in_ready)
        else $error("cell write stalled input");

    // span is ordered
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_draw_start <= i_draw_end)
        else $error("draw span reversed");

endmodule

bind grid_dda_raycast_column gdr_checker u_gdr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_cmd     (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_column (o_out.out_column),
    .i_draw_start (o_out.draw_start),
    .i_draw_end   (o_out.draw_end)
);

// ----- sim/testbench.sv -----
// testbench for grid_dda_raycast_column: cell writes and column casts under random
// idling on both channels, predicted wall columns checked in order by a scoreboard
// depends on gdr_pkg, gdr_in_if, gdr_out_if and the raycaster rtl
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        gdr_pkg::t_cmd cmd;
        logic [5:0]    cell_col;
        logic [5:0]    cell_row;
        logic          cell_is_wall;
        logic [11:0]   column;
    } t_ray_req;

    typedef struct {
        logic [11:0] out_column;
        logic        wall_side;
        logic [7:0]  hit_col;
        logic [7:0]  hit_row;
        logic [15:0] perp_distance;
        logic [15:0] line_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
    } t_wall_col;

    class column_scoreboard;
        logic [15:0] view_regs [8];
        bit          walls [4096];
        t_wall_col   pending_cols [$];
        int          errors;

        function new();
            view_regs[gdr_pkg::REG_SCREEN_WIDTH]  = 16'(gdr_pkg::SCREEN_WIDTH_RST);
            view_regs[gdr_pkg::REG_SCREEN_HEIGHT] = 16'(gdr_pkg::SCREEN_HEIGHT_RST);
            view_regs[gdr_pkg::REG_POS_X]         = gdr_pkg::POS_X_RST;
            view_regs[gdr_pkg::REG_POS_Y]         = gdr_pkg::POS_Y_RST;
            view_regs[gdr_pkg::REG_DIR_X]         = gdr_pkg::DIR_X_RST;
            view_regs[gdr_pkg::REG_DIR_Y]         = gdr_pkg::DIR_Y_RST;
            view_regs[gdr_pkg::REG_PLANE_X]       = gdr_pkg::PLANE_X_RST;
            view_regs[gdr_pkg::REG_PLANE_Y]       = gdr_pkg::PLANE_Y_RST;
            foreach (walls[i]) walls[i] = 0;
            errors = 0;
        endfunction

        function void set_reg(gdr_pkg::t_reg idx, logic [15:0] val);
            if (idx == gdr_pkg::REG_SCREEN_WIDTH || idx == gdr_pkg::REG_SCREEN_HEIGHT)
                view_regs[idx] = {4'd0, val[11:0]};
            else
                view_regs[idx] = val;
        endfunction

        function longint unsigned inv_q16(longint rd);
            longint unsigned m;
            longint unsigned d;
            if (rd == 0) return 64'hFFFF_FFFF;
            m = (rd < 0) ? -rd : rd;
            d = (64'd1 << 30) / m;
            return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
        endfunction

        function void note_input(t_ray_req r);
            longint w, h, cam, rdx, rdy, mx, my, stx, sty, ds, de, half;
            longint unsigned ddx, ddy, sdx, sdy, perp, lh, ph;
            bit side;
            t_wall_col res;
            if (r.cmd == gdr_pkg::CMD_WRITE_CELL) begin
                walls[{r.cell_row, r.cell_col}] = r.cell_is_wall;
                return;
            end
            w = (view_regs[gdr_pkg::REG_SCREEN_WIDTH] == 0) ? 1
                : view_regs[gdr_pkg::REG_SCREEN_WIDTH];
            h = view_regs[gdr_pkg::REG_SCREEN_HEIGHT];
            cam = ((2 * longint'(r.column) - w) * 16384) / w;
            rdx = longint'($signed(view_regs[gdr_pkg::REG_DIR_X]))
                + (longint'($signed(view_regs[gdr_pkg::REG_PLANE_X])) * cam) / 16384;
            rdy = longint'($signed(view_regs[gdr_pkg::REG_DIR_Y]))
                + (longint'($signed(view_regs[gdr_pkg::REG_PLANE_Y])) * cam) / 16384;
            mx = view_regs[gdr_pkg::REG_POS_X][15:10];
            my = view_regs[gdr_pkg::REG_POS_Y][15:10];
            ddx = inv_q16(rdx);
            ddy = inv_q16(rdy);
            if (rdx < 0) begin
                stx = -1;
                sdx = (longint'(view_regs[gdr_pkg::REG_POS_X][9:0]) * ddx) >> 10;
            end else begin
                stx = 1;
                sdx = ((1024 - longint'(view_regs[gdr_pkg::REG_POS_X][9:0])) * ddx) >> 10;
            end
            if (rdy < 0) begin
                sty = -1;
                sdy = (longint'(view_regs[gdr_pkg::REG_POS_Y][9:0]) * ddy) >> 10;
            end else begin
                sty = 1;
                sdy = ((1024 - longint'(view_regs[gdr_pkg::REG_POS_Y][9:0])) * ddy) >> 10;
            end
            side = 0;
            forever begin
                // equal side distances step in y
                if (sdx < sdy) begin
                    sdx += ddx;
                    mx += stx;
                    side = 0;
                end else begin
                    sdy += ddy;
                    my += sty;
                    side = 1;
                end
                // off the map counts as wall
                if (mx < 0 || my < 0 || mx >= 64 || my >= 64) break;
                if (walls[my * 64 + mx]) break;
            end
            perp = side ? sdy - ddy : sdx - ddx;
            if (perp == 0) perp = 6554;
            lh = (longint'(h) << 16) / perp;
            if (lh > 65535) lh = 65535;
            ph = perp >> 8;
            if (ph > 65535) ph = 65535;
            half = h / 2;
            ds = half - longint'(lh / 2);
            if (ds < 0) ds = 0;
            de = half + longint'(lh / 2);
            if (de >= h) de = h - 1;
            if (de < 0) de = 0;
            res.out_column    = r.column;
            res.wall_side     = side;
            res.hit_col       = mx[7:0];
            res.hit_row       = my[7:0];
            res.perp_distance = ph[15:0];
            res.line_height   = lh[15:0];
            res.draw_start    = ds[11:0];
            res.draw_end      = de[11:0];
            pending_cols.push_back(res);
        endfunction

        function void flag(string name, longint exp_v, longint act_v);
            errors++;
            if (errors <= 60)
                $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        endfunction

        function void check_result(t_wall_col act);
            t_wall_col e;
            if (pending_cols.size() == 0) begin
                errors++;
                if (errors <= 60)
                    $display("%0t unexpected result column %0d", $time, act.out_column);
                return;
            end
            e = pending_cols.pop_front();
            if (act.out_column !== e.out_column) flag("out_column", e.out_column, act.out_column);
            if (act.wall_side !== e.wall_side) flag("wall_side", e.wall_side, act.wall_side);
            if (act.hit_col !== e.hit_col) flag("hit_col", e.hit_col, act.hit_col);
            if (act.hit_row !== e.hit_row) flag("hit_row", e.hit_row, act.hit_row);
            if (act.perp_distance !== e.perp_distance)
                flag("perp_distance", e.perp_distance, act.perp_distance);
            if (act.line_height !== e.line_height)
                flag("line_height", e.line_height, act.line_height);
            if (act.draw_start !== e.draw_start) flag("draw_start", e.draw_start, act.draw_start);
            if (act.draw_end !== e.draw_end) flag("draw_end", e.draw_end, act.draw_end);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gdr_in_if  ray_in ();
    gdr_out_if ray_out ();

    grid_dda_raycast_column i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ray_in.sink),
        .o_out   (ray_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    column_scoreboard wall_sb;
    longint unsigned  cycle_count;
    int               burst_left;
    int               stall_mode;
    int               mode_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        cycle_count = 0;
        wall_sb = new();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: ready pattern switches at random among four modes
    initial begin
        ray_out.ready = 1'b0;
        stall_mode = 0;
        mode_left = 0;
    end

    always @(posedge i_clk) begin
        t_wall_col act;
        if (i_rst_n && ray_out.valid && ray_out.ready) begin
            act.out_column    = ray_out.out_column;
            act.wall_side     = ray_out.wall_side;
            act.hit_col       = ray_out.hit_col;
            act.hit_row       = ray_out.hit_row;
            act.perp_distance = ray_out.perp_distance;
            act.line_height   = ray_out.line_height;
            act.draw_start    = ray_out.draw_start;
            act.draw_end      = ray_out.draw_end;
            wall_sb.check_result(act);
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 600);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: ray_out.ready <= 1'b1;
            1: ray_out.ready <= ($urandom_range(0, 1) == 1);
            2: ray_out.ready <= ($urandom_range(0, 7) == 0);
            default: ray_out.ready <= ((cycle_count % 5) < 2);
        endcase
    end

    task automatic apb_write(gdr_pkg::t_reg idx, logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wall_sb.set_reg(idx, val);
    endtask

    task automatic send_req(t_ray_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                ray_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        ray_in.valid        <= 1'b1;
        ray_in.cmd          <= r.cmd;
        ray_in.cell_col     <= r.cell_col;
        ray_in.cell_row     <= r.cell_row;
        ray_in.cell_is_wall <= r.cell_is_wall;
        ray_in.column       <= r.column;
        do @(posedge i_clk); while (!ray_in.ready);
        wall_sb.note_input(r);
    endtask

    task automatic write_cell(int cx, int cy, bit is_wall);
        t_ray_req r;
        r.cmd = gdr_pkg::CMD_WRITE_CELL;
        r.cell_col = cx[5:0];
        r.cell_row = cy[5:0];
        r.cell_is_wall = is_wall;
        r.column = 12'($urandom);
        send_req(r);
    endtask

    task automatic cast(int col);
        t_ray_req r;
        r.cmd = gdr_pkg::CMD_CAST;
        r.cell_col = 6'($urandom);
        r.cell_row = 6'($urandom);
        r.cell_is_wall = 1'($urandom);
        r.column = col[11:0];
        send_req(r);
    endtask

    // wait until every expected column is back (or a guard expires), then hold the input idle
    task automatic drain();
        int guard;
        ray_in.valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (wall_sb.pending_cols.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (500) @(posedge i_clk);
    endtask

    task automatic program_view(int phase);
        logic [15:0] v [8];
        case (phase)
            1: v = '{16'd1, 16'd4095, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
            2: v = '{16'd4095, 16'd1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000,
                     16'h0000};
            3: v = '{16'd0, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom)};
            default: begin
                v[0] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4095))
                                                   : 16'($urandom_range(1, 800));
                v[1] = 16'($urandom_range(1, 4095));
                v[2] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(4096, 61439));
                v[3] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(4096, 61439));
                v[4] = 16'($urandom);
                v[5] = 16'($urandom);
                v[6] = 16'($urandom);
                v[7] = 16'($urandom);
                // axis-aligned view now and then to hit exact boundaries
                if ($urandom_range(0, 3) == 0) begin
                    v[2][9:0] = 10'd0;
                    v[5] = 16'd0;
                    v[6] = 16'd0;
                end
            end
        endcase
        for (int i = 0; i < 8; i++) apb_write(gdr_pkg::t_reg'(i), v[i]);
    endtask

    initial begin
        int w;
        int n;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        ray_in.valid        = 1'b0;
        ray_in.cmd          = gdr_pkg::CMD_WRITE_CELL;
        ray_in.cell_col     = '0;
        ray_in.cell_row     = '0;
        ray_in.cell_is_wall = 1'b0;
        ray_in.column       = '0;
        burst_left          = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, map corners, start cell being a wall, wide columns
        cast(0);
        cast(320);
        cast(639);
        cast(4095);
        write_cell(0, 0, 1);
        write_cell(63, 63, 1);
        write_cell(63, 0, 1);
        write_cell(0, 63, 1);
        write_cell(2, 2, 1);
        cast(0);
        cast(639);
        write_cell(2, 2, 0);
        write_cell(1, 2, 1);
        cast(320);
        write_cell(1, 2, 0);
        write_cell(1, 1, 1);
        write_cell(1, 3, 1);
        write_cell(3, 1, 1);
        cast(1);
        cast(200);
        cast(500);
        cast(2048);
        drain();

        for (int phase = 1; phase <= 10; phase++) begin
            program_view(phase);
            w = (wall_sb.view_regs[gdr_pkg::REG_SCREEN_WIDTH] == 0) ? 1
                : wall_sb.view_regs[gdr_pkg::REG_SCREEN_WIDTH];
            if (phase == 2) begin
                cast(0);
                cast(4095);
            end
            for (int i = 0; i < 40; i++)
                write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 2) != 0);
            n = 0;
            while (n < 95) begin
                if ($urandom_range(0, 4) == 0)
                    write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 1));
                else if ($urandom_range(0, 9) == 0)
                    cast($urandom_range(0, 4095));
                else
                    cast($urandom_range(0, w - 1));
                n++;
            end
            drain();
        end

        if (wall_sb.errors == 0 && wall_sb.pending_cols.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/gdr_pkg.sv
src/gdr_if.sv
src/grid_dda_raycast_column.sv
src/gdr_checker.sv
sim/testbench.sv
